// File: rtl/ogcm_pkg.sv
// Package for the obstacle gradient cost map core.
// Grid sizes, register codes, controller states and the command/status structs.
// No dependencies.
package ogcm_pkg;

	localparam int MAP_ROWS = 64;
	localparam int MAP_COLS = 64;
	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int CNT_W = 7;
	localparam int WIN_W = 4;
	localparam int SLOPE_W = 16;
	localparam int COST_W = 16;
	localparam int MAX_WINDOW = 15;
	localparam int SPAN = 2 * MAX_WINDOW + 1;
	localparam int D2_W = 9;
	localparam int RAD_W = 26;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 3;
	localparam int ITER_W = 4;
	localparam int PROD_W = ROOT_W + SLOPE_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [COST_W-1:0] COST_ONE = 16'd32768;
	localparam logic [CNT_W-1:0] ROWS_MAX = 7'd64;
	localparam logic [CNT_W-1:0] COLS_MAX = 7'd64;

	typedef enum logic [1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_WINDOW = 2'd2,
		REG_SLOPE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_Q_RD,
		ST_Q_CHK,
		ST_SCAN,
		ST_DRAIN,
		ST_SQRT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] row_count;
		logic [CNT_W-1:0] col_count;
		logic [WIN_W-1:0] window_cells;
		logic [SLOPE_W-1:0] cost_slope;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic write;
		logic check;
		logic scan_start;
		logic scan_step;
		logic sqrt_start;
		logic mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic oor;
		logic cell_bit;
		logic win_zero;
		logic scan_last;
		logic pipe_busy;
		logic found;
		logic sqrt_done;
		logic out_free;
	} status_t;

endpackage

// File: rtl/ogcm_if.sv
// Request and result channel interfaces of the cost map core.
// Depends on ogcm_pkg.
interface ogcm_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [ogcm_pkg::ROW_W-1:0] row;
	logic [ogcm_pkg::COL_W-1:0] col;
	logic occupied;

	modport source (output valid, op, row, col, occupied, input ready);
	modport sink (input valid, op, row, col, occupied, output ready);
endinterface

interface ogcm_res_if;
	logic valid;
	logic ready;
	logic [ogcm_pkg::COST_W-1:0] cost;
	logic is_obstacle;
	logic out_of_range;

	modport source (output valid, cost, is_obstacle, out_of_range, input ready);
	modport sink (input valid, cost, is_obstacle, out_of_range, output ready);
endinterface

// File: rtl/obstacle_gradient_cost_map_core.sv
// Obstacle gradient cost map core: top level.
// Holds the configuration registers and the APB port. Depends on ogcm_pkg,
// ogcm_if, ogcm_ctrl, ogcm_datapath.
//
// Usage:
//  - item (request channel, valid/ready): op 0 writes the occupied bit of
//    cell (row, col) and gives no result; op 1 asks for that cell's cost.
//  - result (valid/ready): cost (Q1.15, 32768 = 1.0), is_obstacle and
//    out_of_range, one per query, in request order.
//  - APB: row_count 0x0, col_count 0x4, window_cells 0x8, cost_slope 0xC.
//    Write only while the core is idle; pready is tied high.
// Sequence:
//  - a write: on acceptance the row is read, then written back; the next
//    request is taken once the core is back in idle.
//  - a query: the cell row is read and checked, then one row word of the
//    window per cycle (2*window_cells+1 rows, clipped, at most 31), pipeline
//    drain, 13 square root steps, the slope multiply and the result load; the
//    next request is taken after that. Out of range, obstacle or window 0 skip
//    the scan. The single memory read port reads the window rows one by one.
// Reset: asynchronous, clears the whole grid (per-row valid bits) and loads
//  the register defaults; no clearing pass is needed.
// Stall: one result register; a stalled receiver holds the finished query
//  in the controller until the register frees, the next request waits.
module obstacle_gradient_cost_map_core (
	input  logic                              clk,
	input  logic                              arst_n,
	ogcm_req_if.sink                          item,
	ogcm_res_if.source                        result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ogcm_pkg::PADDR_W-1:0]      paddr,
	input  logic [ogcm_pkg::PDATA_W-1:0]      pwdata,
	output logic [ogcm_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	ogcm_pkg::cfg_t cfg_q;
	ogcm_pkg::cmd_t cmd;
	ogcm_pkg::status_t status;
	ogcm_pkg::reg_idx_t reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = ogcm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count <= 7'd64;
			cfg_q.col_count <= 7'd64;
			cfg_q.window_cells <= 4'd0;
			cfg_q.cost_slope <= 16'd4096;
		end else if (wr_en) begin
			unique case (reg_idx)
				ogcm_pkg::REG_ROW_COUNT: cfg_q.row_count <= pwdata[ogcm_pkg::CNT_W-1:0];
				ogcm_pkg::REG_COL_COUNT: cfg_q.col_count <= pwdata[ogcm_pkg::CNT_W-1:0];
				ogcm_pkg::REG_WINDOW: cfg_q.window_cells <= pwdata[ogcm_pkg::WIN_W-1:0];
				ogcm_pkg::REG_SLOPE: cfg_q.cost_slope <= pwdata[ogcm_pkg::SLOPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ogcm_pkg::REG_ROW_COUNT: prdata = ogcm_pkg::PDATA_W'(cfg_q.row_count);
			ogcm_pkg::REG_COL_COUNT: prdata = ogcm_pkg::PDATA_W'(cfg_q.col_count);
			ogcm_pkg::REG_WINDOW: prdata = ogcm_pkg::PDATA_W'(cfg_q.window_cells);
			ogcm_pkg::REG_SLOPE: prdata = ogcm_pkg::PDATA_W'(cfg_q.cost_slope);
			default: prdata = '0;
		endcase
	end

	ogcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_ready(item.ready),
		.status  (status),
		.cmd     (cmd)
	);

	ogcm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.status      (status),
		.in_op       (item.op),
		.in_row      (item.row),
		.in_col      (item.col),
		.in_occupied (item.occupied),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_cost    (result.cost),
		.out_obstacle(result.is_obstacle),
		.out_oor     (result.out_of_range)
	);
endmodule

// File: rtl/ogcm_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on ogcm_pkg.
module ogcm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ogcm_pkg::RAD_W-1:0]    value,
	output logic [ogcm_pkg::ROOT_W-1:0]   root,
	output logic                          done
);
	logic [ogcm_pkg::RAD_W-1:0] rad_q;
	logic [ogcm_pkg::REM_W-1:0] rem_q;
	logic [ogcm_pkg::ROOT_W-1:0] root_q;
	logic [ogcm_pkg::ITER_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ogcm_pkg::REM_W-1:0] rem_sh;
	logic [ogcm_pkg::REM_W-1:0] trial;
	logic ge;

	assign rem_sh = {rem_q[ogcm_pkg::REM_W-3:0], rad_q[ogcm_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ogcm_pkg::ITER_W'(ogcm_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= value;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[ogcm_pkg::RAD_W-3:0], 2'b00};
			rem_q <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ogcm_pkg::ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

// File: rtl/ogcm_datapath.sv
// Datapath: occupancy row memory, window scan pipeline, minimum distance,
// square root, slope multiply and result register. Depends on ogcm_pkg, ogcm_sqrt.
module ogcm_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ogcm_pkg::cfg_t                  cfg,
	input  ogcm_pkg::cmd_t                  cmd,
	output ogcm_pkg::status_t               status,
	input  logic                            in_op,
	input  logic [ogcm_pkg::ROW_W-1:0]      in_row,
	input  logic [ogcm_pkg::COL_W-1:0]      in_col,
	input  logic                            in_occupied,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [ogcm_pkg::COST_W-1:0]     out_cost,
	output logic                            out_obstacle,
	output logic                            out_oor
);
	// item
	logic op_q;
	logic [ogcm_pkg::ROW_W-1:0] row_q;
	logic [ogcm_pkg::COL_W-1:0] col_q;
	logic occ_q;

	// memory
	logic [ogcm_pkg::MAP_COLS-1:0] mem [ogcm_pkg::MAP_ROWS];
	logic [ogcm_pkg::MAP_ROWS-1:0] valid_q;
	logic [ogcm_pkg::MAP_COLS-1:0] raw_s1;
	logic vbit_s1;
	logic [ogcm_pkg::MAP_COLS-1:0] word_s1;
	logic [ogcm_pkg::ROW_W-1:0] raddr;
	logic [ogcm_pkg::MAP_COLS-1:0] wr_word;

	// geometry
	logic [ogcm_pkg::CNT_W-1:0] rows;
	logic [ogcm_pkg::CNT_W-1:0] cols;
	logic [ogcm_pkg::ROW_W-1:0] r0;
	logic [ogcm_pkg::ROW_W-1:0] r1;
	logic [ogcm_pkg::CNT_W-1:0] r_hi;
	logic [ogcm_pkg::CNT_W-1:0] r_lim;
	logic oor;

	// scan
	logic [ogcm_pkg::ROW_W-1:0] rr_q;
	logic [ogcm_pkg::ROW_W-1:0] rdiff;
	logic v_s1;
	logic [ogcm_pkg::WIN_W-1:0] dr_s1;
	logic v_s2;
	logic hit_s2;
	logic [ogcm_pkg::WIN_W-1:0] dr_s2;
	logic [ogcm_pkg::WIN_W-1:0] dc_s2;
	logic [ogcm_pkg::MAP_COLS+2*ogcm_pkg::MAX_WINDOW-1:0] ext;
	logic [ogcm_pkg::SPAN-1:0] win;
	logic [ogcm_pkg::MAX_WINDOW:0] near;
	logic [ogcm_pkg::WIN_W-1:0] dc_min;
	logic hit;
	logic [ogcm_pkg::D2_W-1:0] d2;
	logic [ogcm_pkg::D2_W-1:0] best_q;
	logic found_q;
	logic cell_occ_q;
	logic oor_q;

	// cost
	logic [ogcm_pkg::ROOT_W-1:0] root;
	logic sqrt_done;
	logic [ogcm_pkg::PROD_W-1:0] prod_q;
	logic [ogcm_pkg::PROD_W-6:0] t;
	logic [ogcm_pkg::COST_W-1:0] grad_cost;
	logic out_valid_q;
	logic [ogcm_pkg::COST_W-1:0] cost_q;
	logic obst_q;
	logic oorf_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			row_q <= in_row;
			col_q <= in_col;
			occ_q <= in_occupied;
		end
	end

	assign rows = (cfg.row_count > ogcm_pkg::ROWS_MAX) ? ogcm_pkg::ROWS_MAX : cfg.row_count;
	assign cols = (cfg.col_count > ogcm_pkg::COLS_MAX) ? ogcm_pkg::COLS_MAX : cfg.col_count;
	assign oor = ({1'b0, row_q} >= rows) || ({1'b0, col_q} >= cols);
	assign r0 = (row_q >= ogcm_pkg::ROW_W'(cfg.window_cells)) ?
		row_q - ogcm_pkg::ROW_W'(cfg.window_cells) : '0;
	assign r_hi = {1'b0, row_q} + ogcm_pkg::CNT_W'(cfg.window_cells);
	assign r_lim = rows - 1'b1;
	assign r1 = (r_hi > r_lim) ? r_lim[ogcm_pkg::ROW_W-1:0] : r_hi[ogcm_pkg::ROW_W-1:0];

	// memory: one read port (registered), one write port
	assign raddr = cmd.scan_step ? rr_q : row_q;
	always_ff @(posedge clk) begin
		raw_s1 <= mem[raddr];
		if (cmd.write) begin
			mem[row_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vbit_s1 <= 1'b0;
		end else begin
			vbit_s1 <= valid_q[raddr];
			if (cmd.write) begin
				valid_q[row_q] <= 1'b1;
			end
		end
	end

	assign word_s1 = vbit_s1 ? raw_s1 : '0;

	always_comb begin
		wr_word = word_s1;
		wr_word[col_q] = occ_q;
	end

	// scan row counter and pipeline
	assign rdiff = (row_q >= rr_q) ? row_q - rr_q : rr_q - row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (v_s2 && hit_s2) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			rr_q <= r0;
		end else if (cmd.scan_step) begin
			rr_q <= rr_q + 1'b1;
		end
		if (cmd.check) begin
			cell_occ_q <= word_s1[col_q] && !oor;
			oor_q <= oor;
		end
		dr_s1 <= rdiff[ogcm_pkg::WIN_W-1:0];
		dr_s2 <= dr_s1;
		dc_s2 <= dc_min;
		hit_s2 <= hit;
		if (v_s2 && hit_s2 && (!found_q || d2 < best_q)) begin
			best_q <= d2;
		end
	end

	// nearest occupied column within the clipped window of the row
	assign ext = {{ogcm_pkg::MAX_WINDOW{1'b0}}, word_s1, {ogcm_pkg::MAX_WINDOW{1'b0}}};

	always_comb begin
		logic [7:0] idx;
		logic [ogcm_pkg::WIN_W-1:0] col_off;
		win = ext[col_q +: ogcm_pkg::SPAN];
		for (int k = 0; k < ogcm_pkg::SPAN; k++) begin
			idx = 8'({2'b00, col_q}) + 8'(k) - 8'(ogcm_pkg::MAX_WINDOW);
			col_off = (k < ogcm_pkg::MAX_WINDOW) ? ogcm_pkg::WIN_W'(ogcm_pkg::MAX_WINDOW - k) :
				ogcm_pkg::WIN_W'(k - ogcm_pkg::MAX_WINDOW);
			if (col_off > cfg.window_cells || idx >= {1'b0, cols}) begin
				win[k] = 1'b0;
			end
		end
		for (int d = 0; d <= ogcm_pkg::MAX_WINDOW; d++) begin
			near[d] = win[ogcm_pkg::MAX_WINDOW - d] | win[ogcm_pkg::MAX_WINDOW + d];
		end
		dc_min = '0;
		for (int d = ogcm_pkg::MAX_WINDOW; d >= 0; d--) begin
			if (near[d]) begin
				dc_min = ogcm_pkg::WIN_W'(d);
			end
		end
		hit = |near;
	end

	assign d2 = ogcm_pkg::D2_W'(dr_s2) * ogcm_pkg::D2_W'(dr_s2) +
		ogcm_pkg::D2_W'(dc_s2) * ogcm_pkg::D2_W'(dc_s2);

	ogcm_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.sqrt_start),
		.value ({1'b0, best_q, 16'b0}),
		.root  (root),
		.done  (sqrt_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= ogcm_pkg::PROD_W'(root) * ogcm_pkg::PROD_W'(cfg.cost_slope);
		end
	end

	assign t = prod_q[ogcm_pkg::PROD_W-1:5];
	assign grad_cost = (t < ogcm_pkg::PROD_W'(32768)) ?
		ogcm_pkg::COST_W'(ogcm_pkg::PROD_W'(32768) - ogcm_pkg::PROD_W'(t)) : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			oorf_q <= oor_q;
			obst_q <= cell_occ_q;
			if (oor_q) begin
				cost_q <= '0;
			end else if (cell_occ_q) begin
				cost_q <= ogcm_pkg::COST_ONE;
			end else if (!found_q) begin
				cost_q <= '0;
			end else begin
				cost_q <= grad_cost;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_cost = cost_q;
	assign out_obstacle = obst_q;
	assign out_oor = oorf_q;

	assign status.is_query = op_q;
	assign status.oor = oor;
	assign status.cell_bit = word_s1[col_q];
	assign status.win_zero = (cfg.window_cells == '0);
	assign status.scan_last = (rr_q == r1);
	assign status.pipe_busy = v_s1 | v_s2;
	assign status.found = found_q;
	assign status.sqrt_done = sqrt_done;
	assign status.out_free = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n) v_s2 |-> $past(v_s1))
		else $error("scan stage 2 without stage 1");
	a_obst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && obst_q |-> cost_q == ogcm_pkg::COST_ONE)
		else $error("obstacle result without full cost");
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && oorf_q |-> cost_q == '0 && !obst_q)
		else $error("out of range result carries cost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(cost_q))
		else $error("result dropped while stalled");
`endif
endmodule

// File: rtl/ogcm_ctrl.sv
// Controller state machine for the cost map core.
// Depends on ogcm_pkg.
module ogcm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ogcm_pkg::status_t    status,
	output ogcm_pkg::cmd_t       cmd
);
	ogcm_pkg::state_t state_q;
	ogcm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ogcm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ogcm_pkg::ST_WR_RD;
				end
			end
			ogcm_pkg::ST_WR_RD: begin
				// row of the item is read here; queries branch off
				state_d = status.is_query ? ogcm_pkg::ST_Q_CHK : ogcm_pkg::ST_WR_WB;
			end
			ogcm_pkg::ST_WR_WB: begin
				cmd.write = 1'b1;
				state_d = ogcm_pkg::ST_IDLE;
			end
			ogcm_pkg::ST_Q_RD: begin
				state_d = ogcm_pkg::ST_Q_CHK;
			end
			ogcm_pkg::ST_Q_CHK: begin
				cmd.check = 1'b1;
				if (status.oor || status.cell_bit || status.win_zero) begin
					state_d = ogcm_pkg::ST_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ogcm_pkg::ST_SCAN;
				end
			end
			ogcm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ogcm_pkg::ST_DRAIN;
				end
			end
			ogcm_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					if (status.found) begin
						cmd.sqrt_start = 1'b1;
						state_d = ogcm_pkg::ST_SQRT;
					end else begin
						state_d = ogcm_pkg::ST_FINISH;
					end
				end
			end
			ogcm_pkg::ST_SQRT: begin
				if (status.sqrt_done) begin
					cmd.mul = 1'b1;
					state_d = ogcm_pkg::ST_FINISH;
				end
			end
			ogcm_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ogcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ogcm_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ogcm_pkg::ST_WR_RD)
		else $error("load did not start a read");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> $past(state_q) == ogcm_pkg::ST_WR_RD && !status.is_query)
		else $error("write back without read");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result register overwritten");
`endif
endmodule
